@@ rtl/cdu_pkg.sv @@
// Shared types, constants and calendar tables for the calendar date unit.
`timescale 1ns / 1ps

package cdu_pkg;

    localparam logic [15:0] YEAR_MIN   = 16'd1900;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  DAY_LAST   = 5'd31;
    localparam logic [4:0]  DAY_FEB_LEAP = 5'd29;
    localparam logic [5:0]  MOD_BASE   = 6'd25;
    localparam logic [8:0]  YEAR_DAYS_NORM = 9'd365;
    localparam logic [8:0]  YEAR_DAYS_LEAP = 9'd366;

    // floor(y / 25) == (y * RECIP_25) >> RECIP_SHIFT for every 16-bit y
    localparam logic [16:0] RECIP_25    = 17'd83887;
    localparam int          RECIP_SHIFT = 21;

    localparam logic ACT_SET = 1'b0;
    localparam logic ACT_ADD = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [15:0] new_year;
        logic [15:0] day_count;
    } cdu_in_t;

    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [15:0] cur_year;
        logic        leap_flag;
        logic [8:0]  day_of_year;
        logic [8:0]  days_left;
        logic        month_bad;
        logic        day_bad;
        logic        year_bad;
        logic        year_overflow;
    } cdu_out_t;

    typedef struct packed {
        logic load_set;
        logic load_add;
        logic mod_step;
        logic day_check;
        logic month_step;
        logic out_load;
    } cdu_cmd_t;

    typedef struct packed {
        logic add_done;
        logic out_free;
    } cdu_status_t;

    // Length of month m (1..12); leap selects 29 days for February.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd2:                    d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = DAY_LAST;
        endcase
        if (m == MONTH_FEB && leap)
            d = DAY_FEB_LEAP;
        return d;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/cdu_ctrl.sv @@
// Sequencer for the calendar date unit: set, mod-25 reduction, add and result hand-off.
`timescale 1ns / 1ps

module cdu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                action,
    input  cdu_pkg::cdu_status_t status,
    output logic                req_ready,
    output cdu_pkg::cdu_cmd_t   cmd
);
    import cdu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       step_cnt_reg, step_cnt_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (action == ACT_ADD)
                    begin
                        cmd.load_add = 1'b1;
                        state_next   = S_ADD;
                    end
                    else
                    begin
                        cmd.load_set  = 1'b1;
                        step_cnt_next = 1'b0;
                        state_next    = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == 1'b1)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.day_check = 1'b1;
                state_next    = S_OUT;
            end
            S_ADD:
            begin
                if (status.add_done)
                    state_next = S_OUT;
                else
                    cmd.month_step = 1'b1;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

endmodule

@@ rtl/cdu_datapath.sv @@
// Date registers, month stepper, mod-25 year tracker and result register.
`timescale 1ns / 1ps

module cdu_datapath #(
    parameter int YEAR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdu_pkg::cdu_in_t     req_data,
    input  cdu_pkg::cdu_cmd_t    cmd,
    input  logic                 rsp_ready,
    output cdu_pkg::cdu_status_t status,
    output logic                 rsp_valid,
    output cdu_pkg::cdu_out_t    rsp_data
);
    import cdu_pkg::*;

    localparam int CMP_W = (YEAR_BITS > 16) ? YEAR_BITS : 16;
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

    logic [3:0]           month_reg;
    logic [4:0]           day_reg;
    logic [YEAR_BITS-1:0] year_reg;
    logic [4:0]           mod_reg;
    logic [15:0]          yval_reg;
    logic [11:0]          quot_reg;
    logic [15:0]          cnt_reg;
    logic                 m_bad_reg, d_bad_reg, y_bad_reg, ovf_reg;
    logic                 rsp_valid_reg;
    cdu_out_t             rsp_data_reg;

    logic        leap;
    logic [4:0]  dim;
    logic [5:0]  rest;
    logic [11:0] quot;
    logic [15:0] quot_x25;
    logic [4:0]  mod_next;
    logic [4:0]  mod_inc;
    logic        m_ok, y_ok;
    logic [15:0] y_load;
    logic [8:0]  doy;
    logic [8:0]  ylen;
    cdu_out_t    result;

    // y % 400 == 0 iff 16 | y and 25 | y
    assign leap = (year_reg[1:0] == 2'b00) && ((mod_reg != 5'd0) || (year_reg[3:0] == 4'd0));
    assign dim  = month_days(month_reg, leap);
    assign rest = 6'(dim) - 6'(day_reg) + 6'd1;

    // two mod steps: quotient by reciprocal multiply, then the remainder
    assign quot     = 12'((33'(yval_reg) * 33'(RECIP_25)) >> RECIP_SHIFT);
    assign quot_x25 = 16'(quot_reg) * 16'(MOD_BASE);
    assign mod_next = 5'(yval_reg - quot_x25);
    assign mod_inc  = (mod_reg == 5'(MOD_BASE - 6'd1)) ? 5'd0 : mod_reg + 5'd1;

    assign m_ok   = (req_data.new_month >= MONTH_JAN) && (req_data.new_month <= MONTH_DEC);
    assign y_ok   = (req_data.new_year >= YEAR_MIN)
                 && (CMP_W'(req_data.new_year) <= CMP_W'(YEAR_MAX));
    assign y_load = y_ok ? req_data.new_year : YEAR_MIN;

    assign doy  = days_before(month_reg) + 9'(day_reg)
                + 9'((leap && (month_reg > MONTH_FEB)) ? 1 : 0);
    assign ylen = leap ? YEAR_DAYS_LEAP : YEAR_DAYS_NORM;

    always_comb
    begin
        result               = '0;
        result.cur_month     = month_reg;
        result.cur_day       = day_reg;
        result.cur_year      = 16'(year_reg);
        result.leap_flag     = leap;
        result.day_of_year   = doy;
        result.days_left     = ylen - doy;
        result.month_bad     = m_bad_reg;
        result.day_bad       = d_bad_reg;
        result.year_bad      = y_bad_reg;
        result.year_overflow = ovf_reg;
    end

    assign status.add_done = (cnt_reg == 16'd0) || ovf_reg;
    assign status.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_data        = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            month_reg <= MONTH_JAN;
            day_reg   <= DAY_FIRST;
            year_reg  <= YEAR_BITS'(YEAR_MIN);
            mod_reg   <= 5'd0;
            m_bad_reg <= 1'b0;
            d_bad_reg <= 1'b0;
            y_bad_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_set)
            begin
                month_reg <= m_ok ? req_data.new_month : MONTH_JAN;
                year_reg  <= YEAR_BITS'(y_load);
                day_reg   <= req_data.new_day;
                mod_reg   <= 5'd0;
                m_bad_reg <= !m_ok;
                y_bad_reg <= !y_ok;
                d_bad_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.load_add)
            begin
                m_bad_reg <= 1'b0;
                y_bad_reg <= 1'b0;
                d_bad_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.mod_step)
            begin
                mod_reg <= mod_next;
            end
            else if (cmd.day_check)
            begin
                if ((day_reg == 5'd0) || (day_reg > dim))
                begin
                    day_reg   <= DAY_FIRST;
                    d_bad_reg <= 1'b1;
                end
            end
            else if (cmd.month_step)
            begin
                if (cnt_reg >= 16'(rest))
                begin
                    if (month_reg >= MONTH_DEC)
                    begin
                        if (year_reg == YEAR_MAX)
                        begin
                            month_reg <= MONTH_DEC;
                            day_reg   <= DAY_LAST;
                            ovf_reg   <= 1'b1;
                        end
                        else
                        begin
                            month_reg <= MONTH_JAN;
                            day_reg   <= DAY_FIRST;
                            year_reg  <= year_reg + YEAR_BITS'(1);
                            mod_reg   <= mod_inc;
                        end
                    end
                    else
                    begin
                        month_reg <= month_reg + 4'd1;
                        day_reg   <= DAY_FIRST;
                    end
                end
                else
                begin
                    day_reg <= day_reg + cnt_reg[4:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_set)
            yval_reg <= y_load;
        if (cmd.mod_step)
            quot_reg <= quot;

        if (cmd.load_add)
            cnt_reg <= req_data.day_count;
        else if (cmd.month_step)
        begin
            if (cnt_reg >= 16'(rest))
                cnt_reg <= cnt_reg - 16'(rest);
            else
                cnt_reg <= 16'd0;
        end

        if (cmd.out_load)
            rsp_data_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

endmodule

@@ rtl/calendar_date_unit.sv @@
// Calendar date unit top level: Gregorian date register with load and add-days.
//
// Holds one Gregorian date. A set transaction loads month, day and year, replaces each invalid
// part with its default (1, 1, 1900) and presents its result after a reciprocal-multiply
// reduction of the year modulo 25 for the century leap test and a check of the day. An add
// transaction advances the date one month per cycle until the count is used up or the year
// overflows, then presents its result. A new transaction is accepted once the previous result
// has been moved into the output register; that register holds the result until it is taken.
`timescale 1ns / 1ps

module calendar_date_unit #(
    parameter int YEAR_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cdu_pkg::cdu_in_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cdu_pkg::cdu_out_t rsp_data
);
    import cdu_pkg::*;

    cdu_cmd_t    cmd;
    cdu_status_t status;

    cdu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (req_data.action),
        .status    (status),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    cdu_datapath #(
        .YEAR_BITS (YEAR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

@@ rtl/cdu_checker.sv @@
// Port-level checks for the calendar date unit and their bind to the top level.
`timescale 1ns / 1ps

module cdu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input cdu_pkg::cdu_out_t rsp_data
);
    import cdu_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.cur_month >= MONTH_JAN) && (rsp_data.cur_month <= MONTH_DEC)
                      && (rsp_data.cur_day != 5'd0))
        else $error("result date out of range");

    a_year_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.day_of_year + rsp_data.days_left)
                      == (rsp_data.leap_flag ? YEAR_DAYS_LEAP : YEAR_DAYS_NORM))
        else $error("day of year and days left disagree with year length");

    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.year_overflow |-> (rsp_data.cur_month == MONTH_DEC)
                      && (rsp_data.cur_day == DAY_LAST)
                      && !rsp_data.month_bad && !rsp_data.day_bad && !rsp_data.year_bad)
        else $error("overflow result not held at end of year");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("accepted a transaction while busy");

endmodule

bind calendar_date_unit cdu_checker u_cdu_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the calendar date unit: set-date and add-days transactions.
`timescale 1ns / 1ps

module testbench;

    import cdu_pkg::*;

    localparam int YEAR_LAST   = (1 << 16) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PHASE_ITEMS = 90;

    class date_scoreboard;
        int month;
        int day;
        int year;
        cdu_out_t predicted_dates[$];
        int errors;
        int checked;
        int n_set;
        int n_add;
        int n_overflow;

        function new();
            month = int'(MONTH_JAN);
            day = int'(DAY_FIRST);
            year = int'(YEAR_MIN);
        endfunction

        static function bit leap_year(int y);
            return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
        endfunction

        static function int month_length(int m, int y);
            case (m)
                2: return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        static function string fmt_date(cdu_out_t r);
            return $sformatf("%0d-%0d-%0d leap=%0d doy=%0d left=%0d bad(m,d,y)=%b%b%b ovf=%0d",
                             r.cur_month, r.cur_day, r.cur_year, r.leap_flag, r.day_of_year,
                             r.days_left, r.month_bad, r.day_bad, r.year_bad, r.year_overflow);
        endfunction

        function void predict_date(cdu_in_t req);
            cdu_out_t r;
            int cnt;
            int rest;
            int doy;
            int ylen;
            r = '0;
            if (req.action == ACT_SET)
            begin
                n_set++;
                if (req.new_month >= MONTH_JAN && req.new_month <= MONTH_DEC)
                    month = int'(req.new_month);
                else
                begin
                    month = int'(MONTH_JAN);
                    r.month_bad = 1'b1;
                end
                if (req.new_year >= YEAR_MIN)
                    year = int'(req.new_year);
                else
                begin
                    year = int'(YEAR_MIN);
                    r.year_bad = 1'b1;
                end
                if (req.new_day >= 1 && int'(req.new_day) <= month_length(month, year))
                    day = int'(req.new_day);
                else
                begin
                    day = int'(DAY_FIRST);
                    r.day_bad = 1'b1;
                end
            end
            else
            begin
                n_add++;
                cnt = int'(req.day_count);
                while (cnt > 0)
                begin
                    rest = month_length(month, year) - day + 1;
                    if (cnt >= rest)
                    begin
                        cnt -= rest;
                        if (month == int'(MONTH_DEC) && year == YEAR_LAST)
                        begin
                            day = int'(DAY_LAST);
                            r.year_overflow = 1'b1;
                            cnt = 0;
                        end
                        else
                        begin
                            if (month == int'(MONTH_DEC))
                            begin
                                month = int'(MONTH_JAN);
                                year++;
                            end
                            else
                                month++;
                            day = int'(DAY_FIRST);
                        end
                    end
                    else
                    begin
                        day += cnt;
                        cnt = 0;
                    end
                end
                if (r.year_overflow)
                    n_overflow++;
            end
            doy = day;
            for (int k = 1; k < month; k++)
                doy += month_length(k, year);
            ylen = int'(leap_year(year) ? YEAR_DAYS_LEAP : YEAR_DAYS_NORM);
            r.cur_month = 4'(month);
            r.cur_day = 5'(day);
            r.cur_year = 16'(year);
            r.leap_flag = leap_year(year);
            r.day_of_year = 9'(doy);
            r.days_left = 9'(ylen - doy);
            predicted_dates.push_back(r);
        endfunction

        function void check_response(cdu_out_t got);
            cdu_out_t want;
            string bad;
            bad = "";
            if (predicted_dates.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: response with nothing outstanding: %s", fmt_date(got));
                return;
            end
            want = predicted_dates.pop_front();
            checked++;
            if (got.cur_month !== want.cur_month) bad = {bad, " cur_month"};
            if (got.cur_day !== want.cur_day) bad = {bad, " cur_day"};
            if (got.cur_year !== want.cur_year) bad = {bad, " cur_year"};
            if (got.leap_flag !== want.leap_flag) bad = {bad, " leap_flag"};
            if (got.day_of_year !== want.day_of_year) bad = {bad, " day_of_year"};
            if (got.days_left !== want.days_left) bad = {bad, " days_left"};
            if (got.month_bad !== want.month_bad) bad = {bad, " month_bad"};
            if (got.day_bad !== want.day_bad) bad = {bad, " day_bad"};
            if (got.year_bad !== want.year_bad) bad = {bad, " year_bad"};
            if (got.year_overflow !== want.year_overflow) bad = {bad, " year_overflow"};
            if (bad != "")
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: response %0d mismatch on%s\n  exp %s\n  got %s",
                             checked, bad, fmt_date(want), fmt_date(got));
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    cdu_in_t  req_data;
    logic     rsp_valid;
    logic     rsp_ready;
    cdu_out_t rsp_data;

    int src_idle_pct;
    int snk_idle_pct;
    bit hold_req;
    int hold_cnt;

    date_scoreboard sb;

    calendar_date_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("ERROR: timeout");
        $display("Test completed with failures");
        $finish;
    end

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp_data);
    end

    task automatic send_item(input cdu_in_t item);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.predict_date(item);
        @(negedge clk);
    endtask

    task automatic drive_set_date(input int m, input int d, input int y);
        cdu_in_t it;
        it = cdu_in_t'({$urandom, $urandom});
        it.action = ACT_SET;
        it.new_month = 4'(m);
        it.new_day = 5'(d);
        it.new_year = 16'(y);
        send_item(it);
    endtask

    task automatic drive_add_days(input int n);
        cdu_in_t it;
        it = cdu_in_t'({$urandom, $urandom});
        it.action = ACT_ADD;
        it.day_count = 16'(n);
        send_item(it);
    endtask

    function automatic cdu_in_t random_item();
        cdu_in_t it;
        int pick;
        int sel;
        it = cdu_in_t'({$urandom, $urandom});
        pick = int'($urandom_range(99));
        if (pick < 35)
        begin
            it.action = ACT_SET;
            it.new_month = 4'($urandom_range(1, 12));
            it.new_year = ($urandom_range(9) == 0) ? 16'($urandom_range(65500, YEAR_LAST))
                                                   : 16'($urandom_range(YEAR_MIN, 2400));
            it.new_day = 5'($urandom_range(1, date_scoreboard::month_length(
                             int'(it.new_month), int'(it.new_year))));
        end
        else if (pick < 50)
        begin
            it.action = ACT_SET;
        end
        else
        begin
            it.action = ACT_ADD;
            sel = int'($urandom_range(99));
            if (sel < 70)
                it.day_count = 16'($urandom_range(0, 60));
            else if (sel < 95)
                it.day_count = 16'($urandom_range(61, 800));
        end
        return it;
    endfunction

    task automatic run_phase(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (PHASE_ITEMS)
            send_item(random_item());
    endtask

    initial
    begin
        int waited;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        hold_req = 1'b0;
        src_idle_pct = 20;
        snk_idle_pct = 20;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drive_add_days(0);
        drive_set_date(0, 0, 0);
        drive_set_date(15, 31, YEAR_LAST);
        drive_set_date(13, 5, 1899);
        drive_set_date(2, 29, 2000);
        drive_set_date(2, 29, 1900);
        drive_set_date(2, 29, 2024);
        drive_set_date(4, 31, 2023);
        drive_set_date(12, 31, 2023);
        drive_add_days(1);
        drive_add_days(0);
        drive_set_date(2, 28, 2100);
        drive_add_days(1);
        drive_set_date(2, 28, 2000);
        drive_add_days(1);
        drive_set_date(12, 31, YEAR_LAST);
        drive_add_days(1);
        drive_set_date(1, 1, 65530);
        drive_add_days(YEAR_LAST);
        drive_set_date(1, 1, 1900);
        drive_add_days(YEAR_LAST);
        drive_set_date(3, 1, 2024);
        drive_add_days(365);

        run_phase(35, 80);
        run_phase(80, 35);
        hold_req = 1'b1;
        run_phase(0, 0);

        req_valid <= 1'b0;
        waited = 0;
        while (sb.predicted_dates.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (sb.predicted_dates.size() != 0)
        begin
            sb.errors++;
            $display("ERROR: %0d responses never arrived", sb.predicted_dates.size());
        end

        $display("Covered %0d set and %0d add transactions, %0d checked, %0d with year overflow.",
                 sb.n_set, sb.n_add, sb.checked, sb.n_overflow);
        $display("Mismatches and protocol errors: %0d", sb.errors);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
